// ----- rtl/core/eovr_pkg.sv -----
// ----------------------------------------------------------------------------
// eovr_pkg
// Shared types and constants of the edit operation vote ranker: request and
// result payloads, request and operation codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package eovr_pkg;

	localparam int SIGMA      = 8;
	localparam int NUM_OPS    = 3;
	localparam int NUM_ROWS   = NUM_OPS * SIGMA;
	localparam int SEED_SLOTS = 16;
	localparam int CNT_W      = 16;
	localparam int WORD_W     = CNT_W + 1;
	localparam int MARK_BIT   = CNT_W;
	localparam int SCORE_W    = 24;
	localparam int WT_W       = 8;
	localparam int WT_DEPTH   = 64;
	localparam int CFG_DATA_W = 48;
	localparam int LEN_W      = 5;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [WT_W-1:0]  PLAIN_WEIGHT = 8'd2;

	typedef enum logic [1:0] {
		REQ_TALLY = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_LOAD  = 2'd2,
		REQ_FETCH = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		OP_INS = 2'd0,
		OP_SUB = 2'd1,
		OP_DEL = 2'd2
	} op_t;

	typedef enum logic {
		CFG_SEED_LENGTH  = 1'b0,
		CFG_SEED_SYMBOLS = 1'b1
	} cfg_reg_t;

	typedef logic [SEED_SLOTS-1:0][2:0] seed_syms_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] position;
		logic [1:0] operation;
		logic [2:0] symbol;
		logic [2:0] weight_row;
		logic [7:0] weight_value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [23:0] score;
		logic [3:0]  out_position;
		logic [1:0]  out_operation;
		logic [2:0]  out_symbol;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic clr_wr;
		logic tly_rd;
		logic tly_wr;
		logic wt_wr;
		logic scan_init;
		logic scan_rd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic len_zero;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/eovr_ctrl.sv -----
// ----------------------------------------------------------------------------
// eovr_ctrl
// Sequencer of the ranker: clear sweep, tally read-modify-write, weight load,
// and the fetch scan with its drain and result hand-off.
// ----------------------------------------------------------------------------
module eovr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_type,
	output logic              req_stall,
	input  eovr_pkg::sts_t    sts,
	output eovr_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_TLY_RD = 7'b0000100,
		S_TLY_WR = 7'b0001000,
		S_SCAN   = 7'b0010000,
		S_DRAIN  = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					unique case (eovr_pkg::req_type_t'(req_type))
						eovr_pkg::REQ_TALLY: state_d = S_TLY_RD;
						eovr_pkg::REQ_CLEAR: state_d = S_CLEAR;
						eovr_pkg::REQ_LOAD:  cmd.wt_wr = 1'b1;
						eovr_pkg::REQ_FETCH: begin
							cmd.scan_init = 1'b1;
							state_d       = S_SCAN;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_TLY_RD: begin
				cmd.tly_rd = 1'b1;
				state_d    = S_TLY_WR;
			end
			S_TLY_WR: begin
				cmd.tly_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_SCAN: begin
				if (sts.len_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.scan_rd = 1'b1;
					if (sts.scan_last) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				// wait for the last entries to reach the compare
				if (!sts.pipe_busy) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// hold until the result register is free
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

// ----- rtl/core/eovr_dpath.sv -----
// ----------------------------------------------------------------------------
// eovr_dpath
// Datapath of the ranker: count/mark memory, weight memory, configuration
// registers, scan counters, score pipeline, best-entry tracking and the
// result register.
// ----------------------------------------------------------------------------
module eovr_dpath #(
	parameter int MAX_LEN = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  eovr_pkg::cmd_t                       cmd,
	output eovr_pkg::sts_t                       sts,
	input  eovr_pkg::req_t                       req_data,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [eovr_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output eovr_pkg::rsp_t                       rsp_data
);

	localparam int NUM_CELLS = eovr_pkg::NUM_ROWS * MAX_LEN;
	localparam int AW        = $clog2(NUM_CELLS);
	localparam int PW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LEN_CAP   = (MAX_LEN < eovr_pkg::SEED_SLOTS) ? MAX_LEN
	                                                            : eovr_pkg::SEED_SLOTS;
	localparam int CW        = 7;

	// configuration
	logic [eovr_pkg::LEN_W-1:0] seed_len_q;
	eovr_pkg::seed_syms_t       seed_syms_q;
	logic [eovr_pkg::LEN_W-1:0] len_eff;

	// request
	eovr_pkg::req_t req_q;
	logic           tly_ok;
	logic [AW-1:0]  tly_addr;

	// memories
	logic [eovr_pkg::WORD_W-1:0] cnt_mem [NUM_CELLS];
	logic [eovr_pkg::WT_W-1:0]   wt_mem  [eovr_pkg::WT_DEPTH];
	logic                        mem_we;
	logic [AW-1:0]               wr_addr;
	logic [eovr_pkg::WORD_W-1:0] wr_data;
	logic                        mem_re;
	logic [AW-1:0]               rd_addr;

	// sweep and scan counters
	logic [AW-1:0] clr_addr_q;
	logic [4:0]    scan_row_q;
	logic [PW-1:0] scan_pos_q;
	logic [AW-1:0] scan_addr;
	logic [3:0]    scan_slot;
	logic [5:0]    wt_rd_addr;
	logic          pos_wrap;

	// score pipeline
	logic                          v_s1;
	logic [eovr_pkg::WORD_W-1:0]   rd_s1;
	logic [eovr_pkg::WT_W-1:0]     wt_s1;
	logic [4:0]                    row_s1;
	logic [PW-1:0]                 pos_s1;
	logic [AW-1:0]                 addr_s1;
	logic [eovr_pkg::WT_W-1:0]     mult_s1;
	logic                          v_s2;
	logic                          elig_s2;
	logic [eovr_pkg::SCORE_W-1:0]  score_s2;
	logic [4:0]                    row_s2;
	logic [PW-1:0]                 pos_s2;
	logic [AW-1:0]                 addr_s2;
	logic [eovr_pkg::CNT_W-1:0]    cnt_s2;

	// best entry
	logic                          have_q;
	logic [eovr_pkg::SCORE_W-1:0]  best_score_q;
	logic [4:0]                    best_row_q;
	logic [PW-1:0]                 best_pos_q;
	logic [AW-1:0]                 best_addr_q;
	logic [eovr_pkg::CNT_W-1:0]    best_cnt_q;

	// result
	logic           rsp_valid_q;
	eovr_pkg::rsp_t rsp_q;
	logic           out_free;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_len_q  <= eovr_pkg::LEN_W'(eovr_pkg::SEED_SLOTS);
			seed_syms_q <= '0;
		end else if (cfg_we) begin
			unique case (eovr_pkg::cfg_reg_t'(cfg_index))
				eovr_pkg::CFG_SEED_LENGTH:  seed_len_q  <= cfg_data[eovr_pkg::LEN_W-1:0];
				eovr_pkg::CFG_SEED_SYMBOLS: seed_syms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign len_eff = (seed_len_q > eovr_pkg::LEN_W'(LEN_CAP)) ? eovr_pkg::LEN_W'(LEN_CAP)
	                                                          : seed_len_q;

	// ---------------- request ----------------
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
	end

	assign tly_ok   = (int'(req_q.operation) < eovr_pkg::NUM_OPS) &&
	                  ({1'b0, req_q.position} < len_eff);
	assign tly_addr = AW'({req_q.operation, req_q.symbol}) * AW'(MAX_LEN) +
	                  AW'(req_q.position);

	// ---------------- clear sweep ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= (clr_addr_q == AW'(NUM_CELLS - 1)) ? '0 : clr_addr_q + AW'(1);
		end
	end

	// ---------------- scan counters ----------------
	assign pos_wrap  = (CW'(scan_pos_q) + CW'(1)) == CW'(len_eff);
	assign scan_addr = AW'(scan_row_q) * AW'(MAX_LEN) + AW'(scan_pos_q);
	assign scan_slot = 4'(scan_pos_q);
	assign wt_rd_addr = {seed_syms_q[scan_slot], scan_row_q[2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			scan_pos_q <= '0;
		end else if (cmd.scan_init) begin
			scan_row_q <= '0;
			scan_pos_q <= '0;
		end else if (cmd.scan_rd) begin
			if (pos_wrap) begin
				scan_pos_q <= '0;
				scan_row_q <= scan_row_q + 5'd1;
			end else begin
				scan_pos_q <= scan_pos_q + PW'(1);
			end
		end
	end

	// ---------------- count memory ports ----------------
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = clr_addr_q;
		wr_data = '0;
		priority if (cmd.clr_wr) begin
			mem_we = 1'b1;
		end else if (cmd.tly_wr) begin
			mem_we  = tly_ok;
			wr_addr = tly_addr;
			wr_data = rd_s1;
			if (rd_s1[eovr_pkg::CNT_W-1:0] != eovr_pkg::COUNT_MAX) begin
				wr_data[eovr_pkg::CNT_W-1:0] = rd_s1[eovr_pkg::CNT_W-1:0] +
				                               eovr_pkg::CNT_W'(1);
			end
		end else if (cmd.finish) begin
			// mark the returned entry
			mem_we  = have_q;
			wr_addr = best_addr_q;
			wr_data = {1'b1, best_cnt_q};
		end
	end

	assign mem_re  = cmd.tly_rd | cmd.scan_rd;
	assign rd_addr = cmd.tly_rd ? tly_addr : scan_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cnt_mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_s1 <= cnt_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wt_wr) begin
			wt_mem[{req_data.weight_row, req_data.symbol}] <= req_data.weight_value;
		end
		if (cmd.scan_rd) begin
			wt_s1 <= wt_mem[wt_rd_addr];
		end
	end

	// ---------------- score pipeline ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_rd;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			row_s1  <= scan_row_q;
			pos_s1  <= scan_pos_q;
			addr_s1 <= scan_addr;
		end
	end

	assign mult_s1 = (eovr_pkg::op_t'(row_s1[4:3]) == eovr_pkg::OP_SUB) ? wt_s1
	                                                                    : eovr_pkg::PLAIN_WEIGHT;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			elig_s2  <= (rd_s1[eovr_pkg::CNT_W-1:0] != '0) && !rd_s1[eovr_pkg::MARK_BIT];
			score_s2 <= eovr_pkg::SCORE_W'(rd_s1[eovr_pkg::CNT_W-1:0]) *
			            eovr_pkg::SCORE_W'(mult_s1);
			cnt_s2   <= rd_s1[eovr_pkg::CNT_W-1:0];
			row_s2   <= row_s1;
			pos_s2   <= pos_s1;
			addr_s2  <= addr_s1;
		end
	end

	// ---------------- best entry ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.scan_init) begin
			have_q <= 1'b0;
		end else if (v_s2 && elig_s2 && (!have_q || score_s2 > best_score_q)) begin
			have_q <= 1'b1;
		end
	end

	// strict compare keeps the earlier entry on a tie
	always_ff @(posedge clk) begin
		if (v_s2 && elig_s2 && (!have_q || score_s2 > best_score_q)) begin
			best_score_q <= score_s2;
			best_row_q   <= row_s2;
			best_pos_q   <= pos_s2;
			best_addr_q  <= addr_s2;
			best_cnt_q   <= cnt_s2;
		end
	end

	// ---------------- result register ----------------
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (have_q) begin
				rsp_q.found         <= 1'b1;
				rsp_q.score         <= best_score_q;
				rsp_q.out_position  <= 4'(best_pos_q);
				rsp_q.out_operation <= best_row_q[4:3];
				rsp_q.out_symbol    <= best_row_q[2:0];
			end else begin
				rsp_q <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// ---------------- status ----------------
	assign sts.clr_last  = (clr_addr_q == AW'(NUM_CELLS - 1));
	assign sts.scan_last = (scan_row_q == 5'(eovr_pkg::NUM_ROWS - 1)) && pos_wrap;
	assign sts.len_zero  = (len_eff == '0);
	assign sts.pipe_busy = v_s1 | v_s2;
	assign sts.out_free  = out_free;

endmodule

// ----- rtl/core/edit_operation_vote_ranker.sv -----
// ----------------------------------------------------------------------------
// edit_operation_vote_ranker
// Tallies edit operations per (operation, symbol, seed position) and returns,
// on each fetch, the highest-scoring entry not yet returned.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   req     | in        | req_valid / req_stall  | req_data  (eovr_pkg::req_t)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_data  (eovr_pkg::rsp_t)
//   cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// After reset and after each clear request the count memory is swept, one
// entry a cycle, all 24*MAX_LEN entries (384 at MAX_LEN 16); req_stall is
// high. A tally reads the addressed entry and writes it back incremented;
// a weight load is written as it is taken. A fetch reads each of the 24*L
// entries once through the single count memory read port, L the active seed
// length. The result waits in an output register; a new item is taken
// meanwhile, and a fetch holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module edit_operation_vote_ranker #(
	parameter int MAX_LEN = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  eovr_pkg::req_t                  req_data,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output eovr_pkg::rsp_t                  rsp_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [eovr_pkg::CFG_DATA_W-1:0] cfg_data
);

	eovr_pkg::cmd_t cmd;
	eovr_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	eovr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_data.req_type),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	eovr_dpath #(
		.MAX_LEN (MAX_LEN)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req_data),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// an empty fetch carries all-zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.found |->
			rsp_data.score == '0 && rsp_data.out_position == '0 &&
			rsp_data.out_operation == '0 && rsp_data.out_symbol == '0)
		else $error("empty fetch result has nonzero fields");

	// insert and delete scores are twice a count
	a_plain_even: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.found &&
		(eovr_pkg::op_t'(rsp_data.out_operation) != eovr_pkg::OP_SUB) |->
			!rsp_data.score[0])
		else $error("odd score for an unweighted operation");

	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.found |->
			int'(rsp_data.out_operation) < eovr_pkg::NUM_OPS &&
			int'(rsp_data.out_position) < MAX_LEN)
		else $error("returned entry outside the table");

	// a fetch result appears only after the request side was stalled
	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result raised without a fetch in progress");

endmodule
